// ===== src/rspc_pkg.sv =====
// shared types and constants for the range scan polar to cartesian unit
package rspc_pkg;

  localparam int ANG_W      = 32;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int GATE_W     = 16;
  localparam int OUT_W      = 17;
  localparam int GAIN_W     = 20;
  localparam int MAX_STAGES = 24;

  localparam logic [GAIN_W-1:0] GAIN_Q20  = 20'd636751;
  localparam logic [OUT_W-1:0]  COORD_MAX = 17'd65535;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_RANGE   = 2'd0,
    REG_MAX_RANGE   = 2'd1,
    REG_START_ANGLE = 2'd2,
    REG_ANGLE_STEP  = 2'd3
  } cfg_reg_t;

  localparam logic [ANG_W-1:0] ATAN_UNITS [MAX_STAGES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

endpackage

// ===== src/rspc_front.sv =====
// config registers, beam angle tracking, range gate and quadrant fold
module rspc_front import rspc_pkg::*; #(
  parameter int RANGE_BITS = 16,
  parameter int ANGLE_BITS = 32,
  parameter int XW         = 34
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [RANGE_BITS-1:0] in_range_mm,
  input  logic                  in_range_invalid,
  input  logic                  in_scan_start,
  output logic                  v_o,
  output logic signed [XW-1:0]  x_o,
  output logic [ANG_W-1:0]      a_o
);

  localparam int CW = (RANGE_BITS > GATE_W) ? RANGE_BITS : GATE_W;
  localparam logic [ANG_W-1:0] ANGLE_MASK = {ANG_W{1'b1}} << (ANG_W - ANGLE_BITS);

  logic [GATE_W-1:0] min_range_r;
  logic [GATE_W-1:0] max_range_r;
  logic [ANG_W-1:0]  start_angle_r;
  logic [ANG_W-1:0]  angle_step_r;
  logic [ANG_W-1:0]  beam_angle_r;
  logic [ANG_W-1:0]  beam_angle_nxt;
  logic              v_r;
  logic signed [XW-1:0] x_r;
  logic [ANG_W-1:0]  a_r;

  logic [ANG_W-1:0]  cur_angle;
  logic [ANG_W-1:0]  masked_angle;
  logic              fold;
  logic              keep;
  logic [CW-1:0]     r_c;
  logic signed [XW-1:0] x_start;

  always_comb begin
    cur_angle      = in_scan_start ? start_angle_r : beam_angle_r;
    beam_angle_nxt = cur_angle + angle_step_r;
    masked_angle   = cur_angle & ANGLE_MASK;
    // second and third quadrant rotate by half a turn
    fold           = masked_angle[ANG_W-1] ^ masked_angle[ANG_W-2];
    r_c            = CW'(in_range_mm);
    keep           = !in_range_invalid && (r_c >= CW'(min_range_r))
                     && (r_c <= CW'(max_range_r));
    x_start        = XW'({in_range_mm, 16'b0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_range_r   <= GATE_W'(120);
      max_range_r   <= GATE_W'(10000);
      start_angle_r <= '0;
      angle_step_r  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_RANGE:   min_range_r   <= cfg_wdata[GATE_W-1:0];
        REG_MAX_RANGE:   max_range_r   <= cfg_wdata[GATE_W-1:0];
        REG_START_ANGLE: start_angle_r <= cfg_wdata[ANG_W-1:0];
        REG_ANGLE_STEP:  angle_step_r  <= cfg_wdata[ANG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beam_angle_r <= '0;
      v_r          <= 1'b0;
    end else if (en) begin
      v_r <= in_valid && keep;
      if (in_valid) begin
        beam_angle_r <= beam_angle_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= fold ? -x_start : x_start;
      a_r <= {masked_angle[ANG_W-1] ^ fold, masked_angle[ANG_W-2:0]};
    end
  end

  assign v_o = v_r;
  assign x_o = x_r;
  assign a_o = a_r;

endmodule

// ===== src/rspc_cell.sv =====
// one rotation cell of the cordic chain
module rspc_cell import rspc_pkg::*; #(
  parameter int IDX = 0,
  parameter int XW  = 34
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 v_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic [ANG_W-1:0]     a_i,
  output logic                 v_o,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic [ANG_W-1:0]     a_o
);

  localparam logic [ANG_W-1:0] ATAN_C = ATAN_UNITS[IDX];

  logic                 v_r;
  logic signed [XW-1:0] x_r;
  logic signed [XW-1:0] y_r;
  logic [ANG_W-1:0]     a_r;
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;

  assign dx = y_i >>> IDX;
  assign dy = x_i >>> IDX;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!a_i[ANG_W-1]) begin
        x_r <= x_i - dx;
        y_r <= y_i + dy;
        a_r <= a_i - ATAN_C;
      end else begin
        x_r <= x_i + dx;
        y_r <= y_i - dy;
        a_r <= a_i + ATAN_C;
      end
    end
  end

  assign v_o = v_r;
  assign x_o = x_r;
  assign y_o = y_r;
  assign a_o = a_r;

endmodule

// ===== src/rspc_gain.sv =====
// cordic gain correction, rounding and saturation over two stages
module rspc_gain import rspc_pkg::*; #(
  parameter int XW = 34
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [XW-1:0]    x_i,
  output logic signed [OUT_W-1:0] q_o
);

  localparam int LO  = 17;
  localparam int PLW = LO + GAIN_W;
  localparam int PHW = XW - LO + GAIN_W + 1;
  localparam int SW  = XW + GAIN_W + 1;
  localparam int QW  = SW - 36;
  localparam int EW  = (QW > OUT_W + 1) ? QW : OUT_W + 1;

  logic [PLW-1:0]          p_lo_r;
  logic signed [PHW-1:0]   p_hi_r;
  logic [PLW-1:0]          p_lo_nxt;
  logic signed [PHW-1:0]   p_hi_nxt;
  logic [SW-1:0]           sum;
  logic signed [EW-1:0]    q_ext;
  logic signed [OUT_W-1:0] q_r;
  logic signed [OUT_W-1:0] q_nxt;

  always_comb begin
    p_lo_nxt = PLW'(x_i[LO-1:0]) * PLW'(GAIN_Q20);
    p_hi_nxt = PHW'($signed(x_i[XW-1:LO])) * $signed(PHW'(GAIN_Q20));
  end

  always_comb begin
    sum   = (SW'(p_hi_r) << LO) + SW'(p_lo_r) + SW'(36'h8_0000_0000);
    q_ext = EW'($signed(sum[SW-1:36]));
    if (q_ext > $signed(EW'(COORD_MAX))) begin
      q_nxt = $signed(COORD_MAX);
    end else if (q_ext < -$signed(EW'(COORD_MAX))) begin
      q_nxt = -$signed(COORD_MAX);
    end else begin
      q_nxt = q_ext[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_lo_r <= p_lo_nxt;
      p_hi_r <= p_hi_nxt;
      q_r    <= q_nxt;
    end
  end

  assign q_o = q_r;

endmodule

// ===== src/range_scan_polar_to_cartesian_unit.sv =====
// top level: lidar range samples to cartesian points
//
// in_* channel: one range sample per transaction (range, invalid flag,
// scan start flag). out_* channel: one point (x, y in signed mm) per
// kept sample; samples that are invalid or outside the inclusive gate
// [min_range, max_range] give no transaction but still advance the angle.
// cfg_*: write enable, register index and data; write only while idle.
// A transaction can be accepted on every cycle while in_ready is high. A point
// on out_* passes, in order, the front register for gating and fold, one
// register per cordic cell, two gain stages for the multiply and rounding,
// and the output register.
// When the receiver stalls, the output register holds its point and one
// more point goes into a skid register; in_ready then drops and the
// whole chain holds until the skid register drains.
// Synchronous reset restores register defaults (min 120, max 10000,
// start angle and step zero), clears the beam angle and empties the chain.
module range_scan_polar_to_cartesian_unit import rspc_pkg::*; #(
  parameter int RANGE_BITS      = 16,
  parameter int ANGLE_BITS      = 32,
  parameter int ROTATION_STAGES = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [RANGE_BITS-1:0]   in_range_mm,
  input  logic                    in_range_invalid,
  input  logic                    in_scan_start,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] out_x_mm,
  output logic signed [OUT_W-1:0] out_y_mm
);

  localparam int XW = RANGE_BITS + 18;
  localparam int NS = ROTATION_STAGES;

  logic                 en;
  logic                 cv [NS+1];
  logic signed [XW-1:0] cx [NS+1];
  logic signed [XW-1:0] cy [NS+1];
  logic [ANG_W-1:0]     ca [NS+1];

  logic                    v_m1_r;
  logic                    v_m2_r;
  logic signed [OUT_W-1:0] tail_x;
  logic signed [OUT_W-1:0] tail_y;

  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_x_r;
  logic signed [OUT_W-1:0] out_y_r;
  logic                    skid_v_r;
  logic signed [OUT_W-1:0] skid_x_r;
  logic signed [OUT_W-1:0] skid_y_r;

  assign en       = !skid_v_r;
  assign in_ready = en;

  rspc_front #(
    .RANGE_BITS (RANGE_BITS),
    .ANGLE_BITS (ANGLE_BITS),
    .XW         (XW)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .en               (en),
    .in_valid         (in_valid),
    .in_range_mm      (in_range_mm),
    .in_range_invalid (in_range_invalid),
    .in_scan_start    (in_scan_start),
    .v_o              (cv[0]),
    .x_o              (cx[0]),
    .a_o              (ca[0])
  );

  assign cy[0] = '0;

  for (genvar i = 0; i < NS; i++) begin : g_cell
    rspc_cell #(
      .IDX (i),
      .XW  (XW)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .v_i   (cv[i]),
      .x_i   (cx[i]),
      .y_i   (cy[i]),
      .a_i   (ca[i]),
      .v_o   (cv[i+1]),
      .x_o   (cx[i+1]),
      .y_o   (cy[i+1]),
      .a_o   (ca[i+1])
    );
  end

  rspc_gain #(.XW(XW)) u_gain_x (
    .clk (clk),
    .en  (en),
    .x_i (cx[NS]),
    .q_o (tail_x)
  );

  rspc_gain #(.XW(XW)) u_gain_y (
    .clk (clk),
    .en  (en),
    .x_i (cy[NS]),
    .q_o (tail_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_m1_r <= 1'b0;
      v_m2_r <= 1'b0;
    end else if (en) begin
      v_m1_r <= cv[NS];
      v_m2_r <= v_m1_r;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else begin
      priority if (skid_v_r) begin
        if (out_ready) begin
          skid_v_r <= 1'b0;
        end
      end else if (v_m2_r) begin
        if (out_valid_r && !out_ready) begin
          skid_v_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end else begin
        if (out_ready) begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_ready) begin
        out_x_r <= skid_x_r;
        out_y_r <= skid_y_r;
      end
    end else if (v_m2_r) begin
      if (out_valid_r && !out_ready) begin
        skid_x_r <= tail_x;
        skid_y_r <= tail_y;
      end else begin
        out_x_r <= tail_x;
        out_y_r <= tail_y;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_x_mm  = out_x_r;
  assign out_y_mm  = out_y_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_valid_r && !out_ready && v_m2_r))
    else $error("skid entry filled without a stalled output");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_x_r != 17'h10000) && (out_y_r != 17'h10000))
    else $error("coordinate outside saturation range");

  assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !out_ready) |=> skid_v_r && $stable(skid_x_r) && $stable(skid_y_r))
    else $error("skid entry lost during stall");

endmodule
